// ===== hdl/ahdd_pkg.sv =====
// ---------------------------------------------------------------------------
// ahdd_pkg: shared types and constants for the hit direction detector
// Motion and hit codes, register indexes, register reset values and
// configuration port widths.
// ---------------------------------------------------------------------------
package ahdd_pkg;

    // Motion state codes
    typedef enum logic [1:0] {
        MODE_STILL    = 2'd0,
        MODE_FORWARD  = 2'd1,
        MODE_BACKWARD = 2'd2
    } mode_t;

    // Hit event codes
    typedef enum logic [1:0] {
        HIT_NONE     = 2'd0,
        HIT_FORWARD  = 2'd1,
        HIT_BACKWARD = 2'd2
    } hit_t;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    // Register indexes
    localparam cfg_index_t REG_FORWARD_START      = 3'd0;
    localparam cfg_index_t REG_BACKWARD_START     = 3'd1;
    localparam cfg_index_t REG_REVERSE_TO_BACKWARD = 3'd2;
    localparam cfg_index_t REG_REVERSE_TO_FORWARD = 3'd3;
    localparam cfg_index_t REG_SETTLE_DELTA       = 3'd4;
    localparam cfg_index_t REG_SETTLE_LEVEL       = 3'd5;

    // Register reset values
    localparam logic signed [15:0] FORWARD_START_RESET       = 16'sd400;
    localparam logic signed [15:0] BACKWARD_START_RESET      = -16'sd200;
    localparam logic signed [15:0] REVERSE_TO_BACKWARD_RESET = -16'sd300;
    localparam logic signed [15:0] REVERSE_TO_FORWARD_RESET  = 16'sd400;
    localparam logic [15:0]        SETTLE_DELTA_RESET        = 16'd20;
    localparam logic [15:0]        SETTLE_LEVEL_RESET        = 16'd200;

endpackage

// ===== hdl/ahdd_channels.sv =====
// ---------------------------------------------------------------------------
// ahdd_channels: valid/ready channel interfaces
// Sample input channel, result output channel and configuration write
// channel of the hit direction detector.
// ---------------------------------------------------------------------------

// Sample channel: one signed acceleration sample per transaction
interface ahdd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_sample;

    modport source (output valid, output accel_sample, input ready);
    modport sink   (input valid, input accel_sample, output ready);
endinterface

// Result channel: hit event and motion state per transaction
interface ahdd_result_if;
    import ahdd_pkg::*;

    logic  valid;
    logic  ready;
    hit_t  hit_event;
    mode_t motion_state;

    modport source (output valid, output hit_event, output motion_state, input ready);
    modport sink   (input valid, input hit_event, input motion_state, output ready);
endinterface

// Configuration write channel
interface ahdd_cfg_if;
    import ahdd_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/accel_hit_direction_detector_core.sv =====
// ---------------------------------------------------------------------------
// accel_hit_direction_detector_core: accelerometer hit direction detector
// Tracks still / forward / backward motion from X-axis samples and flags a
// hit when the motion reverses.
// ---------------------------------------------------------------------------
// One result transaction comes out for every sample transaction taken in.
// The block is a two-register pipeline (input register, result register)
// with the motion state and the sample history updated in the compute stage,
// so it takes one sample per clock cycle while the output is not stalled;
// each sample passes from the input register to the result register, with
// any output stall holding off the input.
// Configuration writes go through a separate channel that is always ready;
// writes to indexes past the last register are dropped. Registers must only
// be written while no samples are in flight.
// ---------------------------------------------------------------------------
module accel_hit_direction_detector_core #(
    parameter int SETTLE_LAG  = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    ahdd_sample_if.sink   sample,
    ahdd_result_if.source result,
    ahdd_cfg_if.sink      cfg
);
    import ahdd_pkg::*;

    // Compare width: covers a full-precision difference of two samples and
    // the 16-bit registers with sign room to spare.
    localparam int BASE_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int CW        = BASE_BITS + 2;

    // Configuration registers
    logic signed [15:0] fwd_start_reg;
    logic signed [15:0] bwd_start_reg;
    logic signed [15:0] rev_bwd_reg;
    logic signed [15:0] rev_fwd_reg;
    logic [15:0]        settle_delta_reg;
    logic [15:0]        settle_level_reg;

    // Pipeline registers
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          out_valid_reg;
    hit_t                          out_hit_reg;
    mode_t                         out_mode_reg;

    // State
    mode_t                         mode_reg;
    mode_t                         mode_next;
    hit_t                          hit_next;
    logic signed [SAMPLE_BITS-1:0] hist_reg [SETTLE_LAG];

    logic advance;
    logic settled;

    logic signed [CW-1:0] cur_ext;
    logic signed [CW-1:0] old_ext;
    logic signed [CW-1:0] diff;
    logic signed [CW-1:0] diff_abs;
    logic signed [CW-1:0] cur_abs;
    logic signed [CW-1:0] fwd_start_ext;
    logic signed [CW-1:0] bwd_start_ext;
    logic signed [CW-1:0] rev_bwd_ext;
    logic signed [CW-1:0] rev_fwd_ext;
    logic signed [CW-1:0] delta_ext;
    logic signed [CW-1:0] level_ext;

    // Handshakes
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign result.valid        = out_valid_reg;
    assign result.hit_event    = out_hit_reg;
    assign result.motion_state = out_mode_reg;

    // Configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_start_reg    <= FORWARD_START_RESET;
            bwd_start_reg    <= BACKWARD_START_RESET;
            rev_bwd_reg      <= REVERSE_TO_BACKWARD_RESET;
            rev_fwd_reg      <= REVERSE_TO_FORWARD_RESET;
            settle_delta_reg <= SETTLE_DELTA_RESET;
            settle_level_reg <= SETTLE_LEVEL_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FORWARD_START:       fwd_start_reg    <= cfg.data;
                REG_BACKWARD_START:      bwd_start_reg    <= cfg.data;
                REG_REVERSE_TO_BACKWARD: rev_bwd_reg      <= cfg.data;
                REG_REVERSE_TO_FORWARD:  rev_fwd_reg      <= cfg.data;
                REG_SETTLE_DELTA:        settle_delta_reg <= cfg.data;
                REG_SETTLE_LEVEL:        settle_level_reg <= cfg.data;
                default:                 ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            in_sample_reg <= sample.accel_sample;
    end

    // Operand extension to a common signed width
    always_comb
    begin
        cur_ext       = {{(CW-SAMPLE_BITS){in_sample_reg[SAMPLE_BITS-1]}}, in_sample_reg};
        old_ext       = {{(CW-SAMPLE_BITS){hist_reg[SETTLE_LAG-1][SAMPLE_BITS-1]}},
                         hist_reg[SETTLE_LAG-1]};
        fwd_start_ext = {{(CW-16){fwd_start_reg[15]}}, fwd_start_reg};
        bwd_start_ext = {{(CW-16){bwd_start_reg[15]}}, bwd_start_reg};
        rev_bwd_ext   = {{(CW-16){rev_bwd_reg[15]}}, rev_bwd_reg};
        rev_fwd_ext   = {{(CW-16){rev_fwd_reg[15]}}, rev_fwd_reg};
        delta_ext     = {{(CW-16){1'b0}}, settle_delta_reg};
        level_ext     = {{(CW-16){1'b0}}, settle_level_reg};
    end

    // Settle test: near rest and steady against the oldest history sample
    always_comb
    begin
        diff     = cur_ext - old_ext;
        diff_abs = diff[CW-1] ? -diff : diff;
        cur_abs  = cur_ext[CW-1] ? -cur_ext : cur_ext;
        settled  = (diff_abs < delta_ext) && (cur_abs < level_ext);
    end

    // Motion state next value
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_STILL:
            begin
                if (cur_ext < bwd_start_ext)
                    mode_next = MODE_BACKWARD;
                else if (cur_ext > fwd_start_ext)
                    mode_next = MODE_FORWARD;
            end
            MODE_FORWARD:
            begin
                if (cur_ext < rev_bwd_ext)
                    mode_next = MODE_BACKWARD;
                else if (settled)
                    mode_next = MODE_STILL;
            end
            MODE_BACKWARD:
            begin
                if (cur_ext > rev_fwd_ext)
                    mode_next = MODE_FORWARD;
                else if (settled)
                    mode_next = MODE_STILL;
            end
            default:
                mode_next = MODE_STILL;
        endcase
    end

    // Hit event output
    always_comb
    begin
        hit_next = HIT_NONE;
        unique case (mode_reg)
            MODE_STILL:    hit_next = HIT_NONE;
            MODE_FORWARD:  if (cur_ext < rev_bwd_ext) hit_next = HIT_BACKWARD;
            MODE_BACKWARD: if (cur_ext > rev_fwd_ext) hit_next = HIT_FORWARD;
            default:       hit_next = HIT_NONE;
        endcase
    end

    // State and history update, one step per sample moved to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STILL;
            for (int i = 0; i < SETTLE_LAG; i++)
                hist_reg[i] <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            mode_reg <= mode_next;
            for (int i = SETTLE_LAG - 1; i > 0; i--)
                hist_reg[i] <= hist_reg[i-1];
            hist_reg[0] <= in_sample_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            out_hit_reg  <= hit_next;
            out_mode_reg <= mode_next;
        end
    end

endmodule

// ===== tb/sv/accel_hit_direction_detector_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// accel_hit_direction_detector_core_test: self-checking bench for the detector
// Feeds signed X-axis samples through the sample channel under random
// sender gaps and receiver stalls. A cycle-free motion tracker predicts hit
// event and motion state for every sample. Each result transaction is
// checked in order against that prediction. Register settings are changed
// between phases while the block is idle.
// ---------------------------------------------------------------------------
module accel_hit_direction_detector_core_test;
    import ahdd_pkg::*;

    localparam int HISTORY_DEPTH = 3;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASE_COUNT   = 7;

    // Out of range register indexes; writes there must be dropped
    localparam cfg_index_t FIRST_SPARE_REG = REG_SETTLE_LEVEL + 3'd1;
    localparam cfg_index_t LAST_SPARE_REG  = '1;

    typedef struct {
        hit_t  hit;
        mode_t mode;
    } motion_result_t;

    typedef enum {
        NEAR_LEVEL,
        NEAR_REST,
        STEADY,
        EXTREME,
        ANY_VALUE
    } sample_kind_t;

    logic clk;
    logic rst_n;

    ahdd_sample_if #(.SAMPLE_BITS(16)) sample_ch();
    ahdd_result_if                     result_ch();
    ahdd_cfg_if                        cfg_ch();

    accel_hit_direction_detector_core #(
        .SETTLE_LAG  (HISTORY_DEPTH),
        .SAMPLE_BITS (16)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Samples waiting to go out, and predicted results waiting to come back
    logic signed [15:0] pending_samples[$];
    motion_result_t     expected_motion[$];

    // Tracker copy of the block state and registers
    mode_t              tracked_mode = MODE_STILL;
    logic signed [15:0] recent_samples[HISTORY_DEPTH] = '{default: '0};
    int fwd_start_lvl    = FORWARD_START_RESET;
    int back_start_lvl   = BACKWARD_START_RESET;
    int rev_back_lvl     = REVERSE_TO_BACKWARD_RESET;
    int rev_fwd_lvl      = REVERSE_TO_FORWARD_RESET;
    int settle_delta_lvl = SETTLE_DELTA_RESET;
    int settle_level_lvl = SETTLE_LEVEL_RESET;

    int fail_count = 0;
    int sample_gap_left = 0;
    int result_stall_left = 0;
    bit sender_idles = 1'b1;
    bit receiver_stalls = 1'b1;
    int last_sample = 0;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int draw_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] clamp_sample(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Motion tracker: next state and hit for one sample
    function automatic motion_result_t step_motion_tracker(logic signed [15:0] cur);
        motion_result_t res;
        int now_val;
        int lag_val;
        int swing;
        int mag;
        bit steady;
        now_val = cur;
        lag_val = recent_samples[HISTORY_DEPTH-1];
        swing   = now_val - lag_val;
        if (swing < 0)
            swing = -swing;
        mag = (now_val < 0) ? -now_val : now_val;
        steady = (swing < settle_delta_lvl) && (mag < settle_level_lvl);
        res.hit = HIT_NONE;
        case (tracked_mode)
            MODE_STILL:
            begin
                if (now_val > fwd_start_lvl)
                    tracked_mode = MODE_FORWARD;
                // backward wins when both start levels are met
                if (now_val < back_start_lvl)
                    tracked_mode = MODE_BACKWARD;
            end
            MODE_FORWARD:
            begin
                if (now_val < rev_back_lvl)
                begin
                    res.hit = HIT_BACKWARD;
                    tracked_mode = MODE_BACKWARD;
                end
                else if (steady)
                    tracked_mode = MODE_STILL;
            end
            MODE_BACKWARD:
            begin
                if (now_val > rev_fwd_lvl)
                begin
                    res.hit = HIT_FORWARD;
                    tracked_mode = MODE_FORWARD;
                end
                else if (steady)
                    tracked_mode = MODE_STILL;
            end
            default: ;
        endcase
        for (int i = HISTORY_DEPTH - 1; i > 0; i--)
            recent_samples[i] = recent_samples[i-1];
        recent_samples[0] = cur;
        res.mode = tracked_mode;
        return res;
    endfunction

    // Sample driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_ch.valid        <= 1'b0;
            sample_ch.accel_sample <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                void'(pending_samples.pop_front());
            // hold the current transaction while it is stalled
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (sample_gap_left > 0)
                begin
                    sample_gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_ch.valid        <= 1'b1;
                    sample_ch.accel_sample <= pending_samples[0];
                    if (sender_idles)
                        sample_gap_left = draw_idle_len();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (result_stall_left > 0)
        begin
            result_stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if (receiver_stalls && $urandom_range(0, 3) == 0)
                result_stall_left = draw_idle_len();
        end
    end

    // Monitor: check results, track register writes, predict accepted samples
    always @(posedge clk)
    begin
        motion_result_t want;
        bit bad;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_motion.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: hit %0d state %0d",
                                 result_ch.hit_event, result_ch.motion_state);
                end
                else
                begin
                    want = expected_motion.pop_front();
                    bad  = 1'b0;
                    if (result_ch.hit_event !== want.hit)
                        bad = 1'b1;
                    if (result_ch.motion_state !== want.mode)
                        bad = 1'b1;
                    if (bad)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t: hit exp %0d got %0d, state exp %0d got %0d",
                                     $realtime, want.hit, result_ch.hit_event,
                                     want.mode, result_ch.motion_state);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_FORWARD_START:       fwd_start_lvl    = int'($signed(cfg_ch.data));
                    REG_BACKWARD_START:      back_start_lvl   = int'($signed(cfg_ch.data));
                    REG_REVERSE_TO_BACKWARD: rev_back_lvl     = int'($signed(cfg_ch.data));
                    REG_REVERSE_TO_FORWARD:  rev_fwd_lvl      = int'($signed(cfg_ch.data));
                    REG_SETTLE_DELTA:        settle_delta_lvl = int'(cfg_ch.data);
                    REG_SETTLE_LEVEL:        settle_level_lvl = int'(cfg_ch.data);
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
                expected_motion.push_back(step_motion_tracker(sample_ch.accel_sample));
        end
    end

    task automatic push_sample(int v);
        pending_samples.push_back(clamp_sample(v));
        last_sample = clamp_sample(v);
    endtask

    // Pause until every sample is out and every result is back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || expected_motion.size() != 0 ||
               sample_ch.valid);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Register setting for one random phase
    task automatic apply_setting(int p);
        cfg_data_t f, b, rb, rf, d, l;
        case (p)
            0:
            begin
                f  = FORWARD_START_RESET;
                b  = BACKWARD_START_RESET;
                rb = REVERSE_TO_BACKWARD_RESET;
                rf = REVERSE_TO_FORWARD_RESET;
                d  = SETTLE_DELTA_RESET;
                l  = SETTLE_LEVEL_RESET;
            end
            2:
            begin
                // everything moves and reverses, settling nearly always allowed
                f  = 16'h8000;
                b  = 16'h7FFF;
                rb = 16'h7FFF;
                rf = 16'h8000;
                d  = 16'hFFFF;
                l  = 16'h8000;
            end
            3:
            begin
                // only full-scale samples move, nothing ever settles
                f  = 16'h7FFE;
                b  = 16'h8001;
                rb = 16'h8001;
                rf = 16'h7FFE;
                d  = 16'h0000;
                l  = 16'h0000;
            end
            4:
            begin
                f  = 16'($urandom);
                b  = 16'($urandom);
                rb = 16'($urandom);
                rf = 16'($urandom);
                d  = 16'($urandom);
                l  = 16'($urandom_range(0, 32768));
            end
            default:
            begin
                f  = 16'($urandom_range(0, 1500));
                b  = 16'(-int'($urandom_range(0, 1500)));
                rb = 16'(-int'($urandom_range(0, 1500)));
                rf = 16'($urandom_range(0, 1500));
                d  = 16'($urandom_range(0, 120));
                l  = 16'($urandom_range(0, 800));
            end
        endcase
        write_reg(REG_FORWARD_START, f);
        write_reg(REG_BACKWARD_START, b);
        write_reg(REG_REVERSE_TO_BACKWARD, rb);
        write_reg(REG_REVERSE_TO_FORWARD, rf);
        write_reg(REG_SETTLE_DELTA, d);
        write_reg(REG_SETTLE_LEVEL, l);
    endtask

    // A short run of samples of one kind, most kinds aimed at the current levels
    task automatic push_burst(ref int pushed);
        sample_kind_t kind;
        int r, len, v, span;
        int levels[4];
        r = $urandom_range(0, 99);
        if (r < 30)
            kind = NEAR_LEVEL;
        else if (r < 55)
            kind = NEAR_REST;
        else if (r < 75)
            kind = STEADY;
        else if (r < 85)
            kind = EXTREME;
        else
            kind = ANY_VALUE;
        levels = '{fwd_start_lvl, back_start_lvl, rev_back_lvl, rev_fwd_lvl};
        len = $urandom_range(1, 5);
        for (int n = 0; n < len; n++)
        begin
            case (kind)
                NEAR_LEVEL:
                    v = levels[$urandom_range(0, 3)] + int'($urandom_range(0, 6)) - 3;
                NEAR_REST:
                begin
                    span = (settle_level_lvl + 4 > 32767) ? 32767 : settle_level_lvl + 4;
                    v = int'($urandom_range(0, 2 * span)) - span;
                end
                STEADY:
                begin
                    span = (settle_delta_lvl > 64) ? 64 : settle_delta_lvl;
                    v = last_sample + int'($urandom_range(0, 2 * span)) - span;
                end
                EXTREME:
                    case ($urandom_range(0, 3))
                        0:       v = -32768;
                        1:       v = 32767;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                default:
                    v = int'($signed(16'($urandom)));
            endcase
            push_sample(v);
            pushed++;
        end
    endtask

    // Stimulus
    initial
    begin
        int pushed;
        rst_n                  = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default levels: start, settle against the zeroed history, reversals
        push_sample(401);
        push_sample(5);
        push_sample(400);
        push_sample(-200);
        push_sample(-201);
        push_sample(400);
        push_sample(401);
        push_sample(-300);
        push_sample(-301);
        push_sample(32767);
        push_sample(-32768);
        push_sample(32767);
        push_sample(0);
        push_sample(-1);
        wait_idle();

        // Spare indexes are ignored; overlapping start levels, backward wins
        write_reg(FIRST_SPARE_REG, 16'h8000);
        write_reg(LAST_SPARE_REG, 16'h7FFF);
        write_reg(REG_FORWARD_START, 16'(-100));
        write_reg(REG_BACKWARD_START, 16'd100);
        push_sample(0);
        push_sample(150);
        push_sample(32767);
        wait_idle();

        // Wide settle window and unreachable reversals
        write_reg(REG_SETTLE_DELTA, 16'hFFFF);
        write_reg(REG_SETTLE_LEVEL, 16'h8000);
        write_reg(REG_REVERSE_TO_BACKWARD, 16'h8000);
        write_reg(REG_REVERSE_TO_FORWARD, 16'h7FFF);
        push_sample(-32768);
        push_sample(-32767);
        push_sample(0);
        push_sample(32767);
        push_sample(32767);
        push_sample(32767);
        push_sample(-32768);
        wait_idle();

        // Random phases, one register setting each
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            sender_idles    = (p != 2);
            receiver_stalls = (p != 2 && p != 5);
            apply_setting(p);
            pushed = 0;
            while (pushed < PHASE_ITEMS / 2)
                push_burst(pushed);
            // hold off new samples until the pipeline has drained
            if (p == 1 || $urandom_range(0, 1) == 0)
                wait_idle();
            while (pushed < PHASE_ITEMS)
                push_burst(pushed);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("accel_hit_direction_detector_core verification clean");
        else
            $display("accel_hit_direction_detector_core verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #6_000_000;
        $display("accel_hit_direction_detector_core verification failed");
        $finish;
    end

endmodule
